>>> src/secd_pkg.sv
// ----------------------------------------------------------------------------
// secd_pkg
// Shared types and constants for the stereo chase-envelope ducker: register
// widths and indexes, reset values, chase-stage widths and rounding codes.
// ----------------------------------------------------------------------------
package secd_pkg;

   // Default sample width (signed, Q1.(N-1)).
   localparam int SAMPLE_BITS_DEF = 24;

   // Configuration register widths.
   localparam int INTENSITY_W = 16;
   localparam int WET_W       = 17;
   localparam int STEP_W      = 21;
   localparam int GAIN_W      = 18;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_INTENSITY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WET_MIX   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DECAY     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_GAIN      = 3'd4;

   // Configuration reset values.
   localparam logic [INTENSITY_W-1:0] INTENSITY_RST = 16'd0;
   localparam logic [WET_W-1:0]       WET_RST       = 17'd65536;
   localparam logic [STEP_W-1:0]      ATTACK_RST    = 21'd107374;
   localparam logic [STEP_W-1:0]      DECAY_RST     = 21'd1074;
   localparam logic [GAIN_W-1:0]      GAIN_RST      = 18'd65536;

   // Chase stages: the first three are signed, the last and the peak are
   // non-negative and never exceed one in Q1.30.
   localparam int STAGE_W = 23;
   localparam int FINAL_W = 31;
   localparam int PEAK_W  = 31;
   localparam int FSUM_W  = 33;
   localparam logic [FINAL_W-1:0] ONE_Q30 = 31'h4000_0000;

   // Second operand of the shared multiplier covers the widest coefficient.
   localparam int OPB_W = 31;

   // Rounding shift applied to a finished product.
   localparam int RND_SEL_W = 2;
   localparam logic [RND_SEL_W-1:0] RND_13 = 2'd0;
   localparam logic [RND_SEL_W-1:0] RND_16 = 2'd1;
   localparam logic [RND_SEL_W-1:0] RND_30 = 2'd2;

   typedef struct packed {
      logic [INTENSITY_W-1:0] intensity;
      logic [WET_W-1:0]       wet_mix;
      logic [STEP_W-1:0]      attack_step;
      logic [STEP_W-1:0]      decay_step;
      logic [GAIN_W-1:0]      rate_gain;
   } cfg_type;

   typedef struct packed {
      logic                 issue;
      logic [RND_SEL_W-1:0] rnd_sel;
   } mul_ctl_type;

endpackage

>>> src/secd_csr.sv
// ----------------------------------------------------------------------------
// secd_csr
// Configuration registers. Writes land on the rising edge while the write
// enable is high; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module secd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [secd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [secd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output secd_pkg::cfg_type                   cfg
);

   secd_pkg::cfg_type cfg_ff;
   secd_pkg::cfg_type cfg_in;

   // Decode the register index and replace the addressed field.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            secd_pkg::REG_INTENSITY: begin
               cfg_in.intensity = csr_wdata[secd_pkg::INTENSITY_W-1:0];
            end
            secd_pkg::REG_WET_MIX: begin
               cfg_in.wet_mix = csr_wdata[secd_pkg::WET_W-1:0];
            end
            secd_pkg::REG_ATTACK: begin
               cfg_in.attack_step = csr_wdata[secd_pkg::STEP_W-1:0];
            end
            secd_pkg::REG_DECAY: begin
               cfg_in.decay_step = csr_wdata[secd_pkg::STEP_W-1:0];
            end
            secd_pkg::REG_GAIN: begin
               cfg_in.rate_gain = csr_wdata[secd_pkg::GAIN_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.intensity   <= secd_pkg::INTENSITY_RST;
         cfg_ff.wet_mix     <= secd_pkg::WET_RST;
         cfg_ff.attack_step <= secd_pkg::ATTACK_RST;
         cfg_ff.decay_step  <= secd_pkg::DECAY_RST;
         cfg_ff.rate_gain   <= secd_pkg::GAIN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> src/secd_mul.sv
// ----------------------------------------------------------------------------
// secd_mul
// Shared unsigned multiplier with a registered product, followed by a
// round-half-up right shift chosen when the product was issued.
// ----------------------------------------------------------------------------
module secd_mul #(
   parameter int A_W = 28
) (
   input  logic                           clock,
   input  secd_pkg::mul_ctl_type          ctl,
   input  logic [A_W-1:0]                 op_a,
   input  logic [secd_pkg::OPB_W-1:0]     op_b,
   output logic [A_W+secd_pkg::OPB_W-1:0] prod,
   output logic [A_W+secd_pkg::OPB_W-13:0] rounded
);

   localparam int P_W   = A_W + secd_pkg::OPB_W;
   localparam int RND_W = P_W - 12;

   logic [P_W-1:0]                 prod_ff;
   logic [P_W-1:0]                 prod_in;
   logic [secd_pkg::RND_SEL_W-1:0] sel_ff;
   logic [secd_pkg::RND_SEL_W-1:0] sel_in;
   logic [P_W:0]                   rnd_sum;

   // Product and its rounding choice load together when a product is issued.
   always_comb begin
      prod_in = prod_ff;
      sel_in  = sel_ff;
      if (ctl.issue) begin
         prod_in = P_W'(op_a) * P_W'(op_b);
         sel_in  = ctl.rnd_sel;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sel_ff  <= sel_in;
   end

   // Add half an output step, then shift right.
   always_comb begin
      rnd_sum = '0;
      rounded = '0;
      case (sel_ff)
         secd_pkg::RND_13: begin
            rnd_sum = {1'b0, prod_ff} + ((P_W + 1)'(1) << 12);
            rounded = RND_W'(rnd_sum >> 13);
         end
         secd_pkg::RND_16: begin
            rnd_sum = {1'b0, prod_ff} + ((P_W + 1)'(1) << 15);
            rounded = RND_W'(rnd_sum >> 16);
         end
         secd_pkg::RND_30: begin
            rnd_sum = {1'b0, prod_ff} + ((P_W + 1)'(1) << 29);
            rounded = RND_W'(rnd_sum >> 30);
         end
         default: begin
            rnd_sum = '0;
            rounded = '0;
         end
      endcase
   end

   assign prod = prod_ff;

endmodule

>>> src/stereo_chase_envelope_ducker.sv
// ----------------------------------------------------------------------------
// stereo_chase_envelope_ducker
// Stereo ducker driven by a four-stage chase envelope of the input level.
//
// Each accepted stereo pair runs through the sequencer states in order before the
// block is ready for the next one: the twelve products of a pair (level
// sense, three stage integrations and four ducking products per channel) all
// go through one shared multiplier, and the three stage integrations depend
// on each other, each taking a multiply state and an add state. The result
// waits in an output register, so a new pair is accepted while the previous
// result is still stalled; the final step of a pair waits only if that
// register is still occupied. Configuration registers may be written only
// while the block is idle.
// ----------------------------------------------------------------------------
module stereo_chase_envelope_ducker #(
   parameter int SAMPLE_BITS = secd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Input transactions
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]      req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0]      req_right_sample,
   input  logic                               req_block_start,
   // Result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   // Configuration writes
   input  logic                               csr_wr_en,
   input  logic [secd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [secd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int A_W    = (SAMPLE_BITS + 4 > 23) ? SAMPLE_BITS + 4 : 23;
   localparam int P_W    = A_W + secd_pkg::OPB_W;
   localparam int RND_W  = P_W - 12;
   localparam int CMP_W  = P_W + SAMPLE_BITS + 3;
   localparam int Y_W    = SAMPLE_BITS + 6;
   localparam int FSUM_W = secd_pkg::FSUM_W;
   localparam int OPB_W  = secd_pkg::OPB_W;

   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [Y_W-1:0] Y_MIN = ~Y_MAX;

   // Sequencer states.
   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE  = 5'd0;
   localparam logic [ST_W-1:0] ST_SENSE = 5'd1;
   localparam logic [ST_W-1:0] ST_STEP  = 5'd2;
   localparam logic [ST_W-1:0] ST_BMUL  = 5'd3;
   localparam logic [ST_W-1:0] ST_BADD  = 5'd4;
   localparam logic [ST_W-1:0] ST_CMUL  = 5'd5;
   localparam logic [ST_W-1:0] ST_CADD  = 5'd6;
   localparam logic [ST_W-1:0] ST_DMUL  = 5'd7;
   localparam logic [ST_W-1:0] ST_DADD  = 5'd8;
   localparam logic [ST_W-1:0] ST_PEAK  = 5'd9;
   localparam logic [ST_W-1:0] ST_DK1   = 5'd10;
   localparam logic [ST_W-1:0] ST_DK2   = 5'd11;
   localparam logic [ST_W-1:0] ST_DK3   = 5'd12;
   localparam logic [ST_W-1:0] ST_DK4   = 5'd13;
   localparam logic [ST_W-1:0] ST_DK5   = 5'd14;
   localparam logic [ST_W-1:0] ST_DK6   = 5'd15;
   localparam logic [ST_W-1:0] ST_DK7   = 5'd16;
   localparam logic [ST_W-1:0] ST_DK8   = 5'd17;
   localparam logic [ST_W-1:0] ST_OUT   = 5'd18;

   secd_pkg::cfg_type     cfg;
   secd_pkg::mul_ctl_type mul_ctl;
   logic [A_W-1:0]        mul_op_a;
   logic [OPB_W-1:0]      mul_op_b;
   logic [P_W-1:0]        mul_prod;
   logic [RND_W-1:0]      mul_rnd;

   logic [ST_W-1:0] state_ff, state_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic signed [SAMPLE_BITS-1:0] xl_ff, xl_in;
   logic signed [SAMPLE_BITS-1:0] xr_ff, xr_in;
   logic [SAMPLE_BITS-1:0] ml_ff, ml_in;
   logic [SAMPLE_BITS-1:0] mr_ff, mr_in;
   logic [SAMPLE_BITS-1:0] mx_ff, mx_in;
   logic [A_W-1:0] tl_ff, tl_in;
   logic [A_W-1:0] tr_ff, tr_in;
   logic signed [secd_pkg::STAGE_W-1:0] first_ff, first_in;
   logic signed [secd_pkg::STAGE_W-1:0] second_ff, second_in;
   logic signed [secd_pkg::STAGE_W-1:0] third_ff, third_in;
   logic [secd_pkg::FINAL_W-1:0] final_ff, final_in;
   logic [secd_pkg::PEAK_W-1:0]  peak_ff, peak_in;

   logic [SAMPLE_BITS-1:0]    mag_l, mag_r;
   logic [CMP_W-1:0]          sense_ext, pk_ext;
   logic                      go_up, go_down;
   logic signed [FSUM_W-1:0]  att_s, dec_s, one_s;
   logic signed [FSUM_W-1:0]  step_sum;
   logic signed [FSUM_W-1:0]  chain_prev, chain_mag, chain_delta, chain_sum;
   logic signed [FSUM_W-1:0]  chain_lo, chain_hi, chain_clamped;
   logic                      chain_neg;
   logic signed [FSUM_W-1:0]  peak_max;
   logic signed [SAMPLE_BITS-1:0] sat_l, sat_r;

   // Clamp a stage value into [lo, hi], upper bound first.
   function automatic logic signed [FSUM_W-1:0] clamp_fs(
      input logic signed [FSUM_W-1:0] v,
      input logic signed [FSUM_W-1:0] lo,
      input logic signed [FSUM_W-1:0] hi
   );
      logic signed [FSUM_W-1:0] r;
      r = v;
      if (r > hi) begin
         r = hi;
      end
      if (r < lo) begin
         r = lo;
      end
      return r;
   endfunction

   // Magnitude of a signed stage for the multiplier.
   function automatic logic [A_W-1:0] stage_mag(
      input logic signed [secd_pkg::STAGE_W-1:0] v
   );
      logic signed [FSUM_W-1:0] w;
      w = FSUM_W'(v);
      if (w < 0) begin
         w = -w;
      end
      return A_W'(w);
   endfunction

   // Apply the ducking amount toward zero and saturate to the sample range.
   function automatic logic signed [SAMPLE_BITS-1:0] duck_sat(
      input logic signed [SAMPLE_BITS-1:0] x,
      input logic [A_W-1:0]                d
   );
      logic signed [Y_W-1:0] xe;
      logic signed [Y_W-1:0] de;
      logic signed [Y_W-1:0] y;
      xe = Y_W'(x);
      de = signed'(Y_W'(d));
      y  = (x < 0) ? xe + de : xe - de;
      if (y > Y_MAX) begin
         y = Y_MAX;
      end
      if (y < Y_MIN) begin
         y = Y_MIN;
      end
      return SAMPLE_BITS'(y);
   endfunction

   secd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   secd_mul #(
      .A_W (A_W)
   ) u_mul (
      .clock   (clock),
      .ctl     (mul_ctl),
      .op_a    (mul_op_a),
      .op_b    (mul_op_b),
      .prod    (mul_prod),
      .rounded (mul_rnd)
   );

   // Input magnitudes, taken when a transaction is accepted.
   assign mag_l = req_left_sample[SAMPLE_BITS-1]  ? SAMPLE_BITS'(-req_left_sample)
                                                  : SAMPLE_BITS'(req_left_sample);
   assign mag_r = req_right_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-req_right_sample)
                                                  : SAMPLE_BITS'(req_right_sample);

   // Level sense against the previous peak on the same scale.
   assign sense_ext = CMP_W'(mul_prod) << 3;
   assign pk_ext    = CMP_W'(peak_ff) << (SAMPLE_BITS - 15);
   assign go_up     = pk_ext < sense_ext;
   assign go_down   = pk_ext > sense_ext;

   assign att_s = signed'(FSUM_W'(cfg.attack_step));
   assign dec_s = signed'(FSUM_W'(cfg.decay_step));
   assign one_s = signed'(FSUM_W'(secd_pkg::ONE_Q30));

   // First stage steps up by attack or down by decay.
   assign step_sum = FSUM_W'(first_ff) + (go_up ? att_s : FSUM_W'(0))
                     - (go_down ? dec_s : FSUM_W'(0));

   // Later stages integrate the rounded, signed product of the stage before.
   always_comb begin
      chain_prev = FSUM_W'(second_ff);
      chain_neg  = first_ff < 0;
      chain_lo   = -att_s;
      chain_hi   = dec_s;
      case (state_ff)
         ST_CADD: begin
            chain_prev = FSUM_W'(third_ff);
            chain_neg  = second_ff < 0;
         end
         ST_DADD: begin
            chain_prev = signed'(FSUM_W'(final_ff));
            chain_neg  = third_ff < 0;
            chain_lo   = FSUM_W'(0);
            chain_hi   = one_s;
         end
         default: begin
            chain_prev = FSUM_W'(second_ff);
            chain_neg  = first_ff < 0;
         end
      endcase
   end

   assign chain_mag     = signed'(FSUM_W'(mul_rnd));
   assign chain_delta   = chain_neg ? -chain_mag : chain_mag;
   assign chain_sum     = chain_prev + chain_delta;
   assign chain_clamped = clamp_fs(chain_sum, chain_lo, chain_hi);

   // Largest of the four stages.
   always_comb begin
      peak_max = FSUM_W'(first_ff);
      if (peak_max < FSUM_W'(second_ff)) begin
         peak_max = FSUM_W'(second_ff);
      end
      if (peak_max < FSUM_W'(third_ff)) begin
         peak_max = FSUM_W'(third_ff);
      end
      if (peak_max < signed'(FSUM_W'(final_ff))) begin
         peak_max = signed'(FSUM_W'(final_ff));
      end
   end

   assign sat_l = duck_sat(xl_ff, tl_ff);
   assign sat_r = duck_sat(xr_ff, tr_ff);

   // Sequencer: schedules the shared multiplier and the stage updates.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      ml_in        = ml_ff;
      mr_in        = mr_ff;
      mx_in        = mx_ff;
      tl_in        = tl_ff;
      tr_in        = tr_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      third_in     = third_ff;
      final_in     = final_ff;
      peak_in      = peak_ff;
      mul_ctl.issue   = 1'b0;
      mul_ctl.rnd_sel = secd_pkg::RND_16;
      mul_op_a        = '0;
      mul_op_b        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xl_in = req_left_sample;
               xr_in = req_right_sample;
               ml_in = mag_l;
               mr_in = mag_r;
               mx_in = (mag_l > mag_r) ? mag_l : mag_r;
               if (req_block_start) begin
                  peak_in = '0;
               end
               state_in = ST_SENSE;
            end
         end
         ST_SENSE: begin
            mul_ctl.issue = 1'b1;
            mul_op_a      = A_W'(mx_ff);
            mul_op_b      = OPB_W'(cfg.intensity);
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            first_in = secd_pkg::STAGE_W'(clamp_fs(step_sum, -att_s, dec_s));
            state_in = ST_BMUL;
         end
         ST_BMUL: begin
            mul_ctl.issue = 1'b1;
            mul_op_a      = stage_mag(first_ff);
            mul_op_b      = OPB_W'(cfg.rate_gain);
            state_in      = ST_BADD;
         end
         ST_BADD: begin
            second_in = secd_pkg::STAGE_W'(chain_clamped);
            state_in  = ST_CMUL;
         end
         ST_CMUL: begin
            mul_ctl.issue = 1'b1;
            mul_op_a      = stage_mag(second_ff);
            mul_op_b      = OPB_W'(cfg.rate_gain);
            state_in      = ST_CADD;
         end
         ST_CADD: begin
            third_in = secd_pkg::STAGE_W'(chain_clamped);
            state_in = ST_DMUL;
         end
         ST_DMUL: begin
            mul_ctl.issue = 1'b1;
            mul_op_a      = stage_mag(third_ff);
            mul_op_b      = OPB_W'(cfg.rate_gain);
            state_in      = ST_DADD;
         end
         ST_DADD: begin
            final_in = secd_pkg::FINAL_W'(chain_clamped);
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            // Left channel ducking starts alongside the peak update.
            peak_in         = secd_pkg::PEAK_W'(peak_max);
            mul_ctl.issue   = 1'b1;
            mul_ctl.rnd_sel = secd_pkg::RND_13;
            mul_op_a        = A_W'(ml_ff);
            mul_op_b        = OPB_W'(cfg.intensity);
            state_in        = ST_DK1;
         end
         ST_DK1: begin
            tl_in           = A_W'(mul_rnd);
            mul_ctl.issue   = 1'b1;
            mul_ctl.rnd_sel = secd_pkg::RND_13;
            mul_op_a        = A_W'(mr_ff);
            mul_op_b        = OPB_W'(cfg.intensity);
            state_in        = ST_DK2;
         end
         ST_DK2: begin
            tr_in         = A_W'(mul_rnd);
            mul_ctl.issue = 1'b1;
            mul_op_a      = tl_ff;
            mul_op_b      = OPB_W'(cfg.intensity);
            state_in      = ST_DK3;
         end
         ST_DK3: begin
            tl_in         = A_W'(mul_rnd);
            mul_ctl.issue = 1'b1;
            mul_op_a      = tr_ff;
            mul_op_b      = OPB_W'(cfg.intensity);
            state_in      = ST_DK4;
         end
         ST_DK4: begin
            tr_in           = A_W'(mul_rnd);
            mul_ctl.issue   = 1'b1;
            mul_ctl.rnd_sel = secd_pkg::RND_30;
            mul_op_a        = tl_ff;
            mul_op_b        = OPB_W'(peak_ff);
            state_in        = ST_DK5;
         end
         ST_DK5: begin
            tl_in           = A_W'(mul_rnd);
            mul_ctl.issue   = 1'b1;
            mul_ctl.rnd_sel = secd_pkg::RND_30;
            mul_op_a        = tr_ff;
            mul_op_b        = OPB_W'(peak_ff);
            state_in        = ST_DK6;
         end
         ST_DK6: begin
            tr_in         = A_W'(mul_rnd);
            mul_ctl.issue = 1'b1;
            mul_op_a      = tl_ff;
            mul_op_b      = OPB_W'(cfg.wet_mix);
            state_in      = ST_DK7;
         end
         ST_DK7: begin
            tl_in         = A_W'(mul_rnd);
            mul_ctl.issue = 1'b1;
            mul_op_a      = tr_ff;
            mul_op_b      = OPB_W'(cfg.wet_mix);
            state_in      = ST_DK8;
         end
         ST_DK8: begin
            tr_in    = A_W'(mul_rnd);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hand the pair to the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_left_in  = sat_l;
               rsp_right_in = sat_r;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and chase state clear on reset; payload does not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
         second_ff    <= '0;
         third_ff     <= '0;
         final_ff     <= '0;
         peak_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         third_ff     <= third_in;
         final_ff     <= final_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      xl_ff        <= xl_in;
      xr_ff        <= xr_in;
      ml_ff        <= ml_in;
      mr_ff        <= mr_in;
      mx_ff        <= mx_in;
      tl_ff        <= tl_in;
      tr_ff        <= tr_in;
   end

   assign req_stall     = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   // The peak and the last stage never exceed one.
   a_peak_range: assert property (@(posedge clock) disable iff (reset)
      peak_ff <= secd_pkg::ONE_Q30)
      else $error("chase peak above one");

   a_final_range: assert property (@(posedge clock) disable iff (reset)
      final_ff <= secd_pkg::ONE_Q30)
      else $error("last chase stage above one");

   // An accepted transaction starts with the level-sense product.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SENSE))
      else $error("sequencer did not start after accept");

   // A new result appears only from the final sequencer step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == ST_OUT))
      else $error("result presented outside the output step");

endmodule
